// ----- src/rtsd_pkg.sv -----
package rtsd_pkg;

  localparam int ACCEL_W    = 16;
  localparam int ROLL_W     = 16;
  localparam int ALPHA_W    = 17;
  localparam int DZ_W       = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam int CORDIC_W   = 27;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int DEG_Q16_W  = 16;
  localparam logic signed [CORDIC_W-1:0] DEG180_Q16 = CORDIC_W'(180 * 65536);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA    = 1'b0,
    CFG_DEADZONE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_CAPTURE = 1'b1
  } op_e;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CORDIC_W-1:0] v;
    unique case (idx)
      5'd0:    v = CORDIC_W'(2949120);
      5'd1:    v = CORDIC_W'(1740967);
      5'd2:    v = CORDIC_W'(919879);
      5'd3:    v = CORDIC_W'(466945);
      5'd4:    v = CORDIC_W'(234379);
      5'd5:    v = CORDIC_W'(117304);
      5'd6:    v = CORDIC_W'(58666);
      5'd7:    v = CORDIC_W'(29335);
      5'd8:    v = CORDIC_W'(14668);
      5'd9:    v = CORDIC_W'(7334);
      5'd10:   v = CORDIC_W'(3667);
      5'd11:   v = CORDIC_W'(1833);
      5'd12:   v = CORDIC_W'(917);
      5'd13:   v = CORDIC_W'(458);
      5'd14:   v = CORDIC_W'(229);
      5'd15:   v = CORDIC_W'(115);
      5'd16:   v = CORDIC_W'(57);
      5'd17:   v = CORDIC_W'(29);
      5'd18:   v = CORDIC_W'(14);
      5'd19:   v = CORDIC_W'(7);
      5'd20:   v = CORDIC_W'(4);
      5'd21:   v = CORDIC_W'(2);
      5'd22:   v = CORDIC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/rtsd_in_if.sv -----
interface rtsd_in_if import rtsd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source (output valid, output opcode, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input opcode, input accel_y, input accel_z, output ready);
endinterface

// ----- src/rtsd_out_if.sv -----
interface rtsd_out_if import rtsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ROLL_W-1:0] output_roll;
  logic signed [ROLL_W-1:0] filtered_roll;
  logic signed [ROLL_W-1:0] neutral_roll;
  logic                     in_deadzone;
  logic                     initialized;

  modport source (output valid, output output_roll, output filtered_roll, output neutral_roll,
                  output in_deadzone, output initialized, input ready);
  modport sink   (input valid, input output_roll, input filtered_roll, input neutral_roll,
                  input in_deadzone, input initialized, output ready);
endinterface

// ----- src/roll_tilt_smoother_deadzone.sv -----
// channel  dir  handshake      payload
// in_i     in   valid/ready    opcode, accel_y, accel_z
// out_o    out  valid/ready    output_roll, filtered_roll, neutral_roll, in_deadzone, initialized
// cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
// a sample runs through the shift-add cordic unit, one rotation per cycle, then the multiply,
// add and deadzone steps; the first sample skips smoothing
// a capture goes from idle straight to done; in_i.ready is high only while the sequencer is idle
// a finished result sits in the output register, so the next item is taken while it waits
// rst_ni clears the angles, sets the first-sample flag and returns the config registers to their defaults
module roll_tilt_smoother_deadzone import rtsd_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int ACCEL_BITS      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rtsd_in_if.sink               in_i,
  rtsd_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
  localparam int DIF_W  = ANG_W + 1;
  localparam int PROD_W = DIF_W + ALPHA_W + 1;
  localparam int CMP_W  = (DIF_W > DZ_W) ? DIF_W : DZ_W;
  localparam logic signed [DIF_W-1:0] HALF = DIF_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [DIF_W-1:0] FULL = DIF_W'(360 << ANGLE_FRAC_BITS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_MUL    = 6'b000100,
    S_ADD    = 6'b001000,
    S_DZ     = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [ALPHA_W-1:0]       alpha_q;
  logic [DZ_W-1:0]          dz_q;
  logic signed [ANG_W-1:0]  filt_q, filt_d, outa_q, outa_d, neut_q, neut_d;
  logic                     first_q, first_d;
  logic                     held_q, held_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     ovalid_q, ovalid_d;
  logic signed [ROLL_W-1:0] o_out_q, o_filt_q, o_neut_q;
  logic                     o_held_q, o_init_q;
  logic                     load_out;

  logic                     in_acc, cstart, cdone;
  logic signed [ANG_W-1:0]  roll;
  logic [ALPHA_W-1:0]       alpha_sat;
  logic signed [DIF_W-1:0]  diff, dwrap, dabs;
  logic signed [PROD_W-1:0] prod_sh;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cstart     = in_acc && (in_i.opcode == OP_SAMPLE);

  rtsd_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .ACCEL_BITS      (ACCEL_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cstart),
    .y_i     (in_i.accel_y),
    .z_i     (in_i.accel_z),
    .done_o  (cdone),
    .roll_o  (roll)
  );

  always_comb begin
    alpha_sat = alpha_q[ALPHA_W-1] ? ALPHA_ONE : alpha_q;
    prod_sh   = prod_q >>> 16;
    diff      = DIF_W'(filt_q) - DIF_W'(neut_q);
    dwrap     = diff;
    if (dwrap >= HALF) begin
      dwrap = dwrap - FULL;
    end
    if (dwrap < -HALF) begin
      dwrap = dwrap + FULL;
    end
    dabs = (dwrap < 0) ? -dwrap : dwrap;

    state_d  = state_q;
    filt_d   = filt_q;
    outa_d   = outa_q;
    neut_d   = neut_q;
    first_d  = first_q;
    held_d   = held_q;
    prod_d   = prod_q;
    load_out = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OP_CAPTURE) begin
            neut_d  = filt_q;
            held_d  = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        if (cdone) begin
          if (first_q) begin
            filt_d  = roll;
            outa_d  = roll;
            neut_d  = roll;
            first_d = 1'b0;
            held_d  = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = $signed({1'b0, alpha_sat}) * (DIF_W'(roll) - DIF_W'(filt_q));
        state_d = S_ADD;
      end
      S_ADD: begin
        filt_d  = filt_q + ANG_W'(prod_sh);
        state_d = S_DZ;
      end
      S_DZ: begin
        if (CMP_W'($unsigned(dabs)) < CMP_W'(dz_q)) begin
          outa_d = neut_q;
          held_d = 1'b1;
        end else begin
          outa_d = filt_q;
          held_d = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    ovalid_d = ovalid_q;
    if (load_out) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      alpha_q  <= ALPHA_W'(13107);
      dz_q     <= DZ_W'(256);
      filt_q   <= '0;
      outa_q   <= '0;
      neut_q   <= '0;
      first_q  <= 1'b1;
      held_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      filt_q   <= filt_d;
      outa_q   <= outa_d;
      neut_q   <= neut_d;
      first_q  <= first_d;
      held_q   <= held_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_ALPHA:    alpha_q <= cfg_data_i;
          CFG_DEADZONE: dz_q    <= cfg_data_i[DZ_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (load_out) begin
      o_out_q  <= ROLL_W'(outa_q);
      o_filt_q <= ROLL_W'(filt_q);
      o_neut_q <= ROLL_W'(neut_q);
      o_held_q <= held_q;
      o_init_q <= !first_q;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.output_roll   = o_out_q;
  assign out_o.filtered_roll = o_filt_q;
  assign out_o.neutral_roll  = o_neut_q;
  assign out_o.in_deadzone   = o_held_q;
  assign out_o.initialized   = o_init_q;

endmodule

// ----- src/rtsd_cordic.sv -----
module rtsd_cordic import rtsd_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int ACCEL_BITS      = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [ACCEL_W-1:0]            y_i,
  input  logic signed [ACCEL_W-1:0]            z_i,
  output logic                                 done_o,
  output logic signed [ANGLE_FRAC_BITS+8:0]    roll_o
);

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int IDX_W  = $clog2(NSTEPS);
  localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
  localparam int SH     = DEG_Q16_W - ANGLE_FRAC_BITS;
  localparam int PRE_SH = ACCEL_W - ACCEL_BITS;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NSTEPS - 1);
  localparam logic signed [CORDIC_W-1:0] RND  = CORDIC_W'(1 << (SH - 1));
  localparam logic signed [CORDIC_W-1:0] HALF = CORDIC_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [CORDIC_W-1:0] FULL = CORDIC_W'(360 << ANGLE_FRAC_BITS);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ITER  = 3'b010,
    C_ROUND = 3'b100
  } cstate_e;

  cstate_e                    state_q, state_d;
  logic [IDX_W-1:0]           cnt_q, cnt_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic                       zero_q, zero_d;
  logic                       done_q, done_d;
  logic signed [ANG_W-1:0]    roll_q, roll_d;

  logic signed [ACCEL_W-1:0]  ys, zs;
  logic signed [CORDIC_W-1:0] y0, x0, dx, dy, ang, rsum, rsh, rwrap;

  always_comb begin
    ys    = y_i >>> PRE_SH;
    zs    = z_i >>> PRE_SH;
    y0    = CORDIC_W'(ys) <<< 8;
    x0    = CORDIC_W'(zs) <<< 8;
    dx    = y_q >>> cnt_q;
    dy    = x_q >>> cnt_q;
    ang   = atan_q16(ATAN_IDX_W'(cnt_q));
    rsum  = RND - acc_q;
    rsh   = rsum >>> SH;
    rwrap = rsh;
    if (rwrap >= HALF) begin
      rwrap = rwrap - FULL;
    end
    if (rwrap < -HALF) begin
      rwrap = rwrap + FULL;
    end

    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    zero_d  = zero_q;
    done_d  = 1'b0;
    roll_d  = roll_q;

    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          zero_d  = (ys == '0) && (zs == '0);
          cnt_d   = '0;
          state_d = C_ITER;
          if (x0 < 0) begin
            x_d   = -x0;
            y_d   = -y0;
            acc_d = (y0 >= 0) ? DEG180_Q16 : -DEG180_Q16;
          end else begin
            x_d   = x0;
            y_d   = y0;
            acc_d = '0;
          end
        end
      end
      C_ITER: begin
        if (y_q > 0) begin
          x_d   = x_q + dx;
          y_d   = y_q - dy;
          acc_d = acc_q + ang;
        end else begin
          x_d   = x_q - dx;
          y_d   = y_q + dy;
          acc_d = acc_q - ang;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          state_d = C_ROUND;
        end
      end
      C_ROUND: begin
        roll_d  = zero_q ? '0 : ANG_W'(rwrap);
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    zero_q <= zero_d;
    roll_q <= roll_d;
  end

  assign done_o = done_q;
  assign roll_o = roll_q;

endmodule
